// ----- rtl/olasd_pkg.sv -----
// Package for the ordered list block: sizes, operation and status codes,
// and the control bundle that the top level broadcasts to every cell.
// No dependencies.
package olasd_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int OUT_CNT_W = 5;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic               append_en;
    logic               delete_en;
    logic [CNT_W-1:0]   count;
    logic [VALUE_W-1:0] key;
  } cell_ctrl_t;

endpackage

// ----- rtl/olasd_if.sv -----
// Request and response channel interfaces of the ordered list block.
// Depends on olasd_pkg.
interface olasd_req_if
  import olasd_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [1:0]                op;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface olasd_rsp_if
  import olasd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [1:0]           status;
  logic [OUT_CNT_W-1:0] count;

  modport source (output valid, output found, output status, output count, input ready);
  modport sink   (input valid, input found, input status, input count, output ready);
endinterface

// ----- rtl/olasd_cell.sv -----
// One cell of the list: holds one entry, compares it with the key and
// takes its right neighbor's entry when a delete closes the gap.
// Depends on olasd_pkg.
module olasd_cell
  import olasd_pkg::*;
(
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic [IDX_W-1:0]   index,
  input  logic [VALUE_W-1:0] next_entry,
  input  logic               prior_in,
  output logic               prior_out,
  output logic [VALUE_W-1:0] entry
);

  logic held;
  logic hit;
  logic shift;
  logic load;

  assign held = CNT_W'(index) < ctrl.count;
  assign hit  = held && (entry == ctrl.key);

  // A match at or below this cell marks everything from here up as moving.
  assign prior_out = prior_in | hit;
  assign shift     = ctrl.delete_en && prior_out;
  assign load      = ctrl.append_en && (CNT_W'(index) == ctrl.count);

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= next_entry;
    end else if (load) begin
      entry <= ctrl.key;
    end
  end

endmodule

// ----- rtl/olasd_top_ctrl.sv -----
// Control of the ordered list: fill count, per-request decode and the
// registered response stage. Depends on olasd_pkg.
module olasd_top_ctrl
  import olasd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  logic [1:0] req_op,
  input  logic [VALUE_W-1:0] req_key,
  input  logic       match_any,
  output cell_ctrl_t ctrl,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output logic       rsp_found,
  output logic [1:0] rsp_status,
  output logic [OUT_CNT_W-1:0] rsp_count
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             full;
  logic             found_next;
  status_t          status_next;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign full      = count == CNT_W'(DEPTH);

  always_comb begin
    ctrl.append_en = 1'b0;
    ctrl.delete_en = 1'b0;
    ctrl.count     = count;
    ctrl.key       = req_key;
    count_next     = count;
    found_next     = 1'b0;
    status_next    = ST_OK;
    case (req_op)
      OP_APPEND: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.append_en = accept;
          count_next     = count + CNT_W'(1);
        end
      end
      OP_SEARCH: begin
        found_next = match_any;
      end
      OP_DELETE: begin
        ctrl.delete_en = accept;
        found_next     = match_any;
        if (match_any) begin
          count_next = count - CNT_W'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_found  <= found_next;
      rsp_status <= status_next;
      rsp_count  <= OUT_CNT_W'(count_next);
    end
  end

endmodule

// ----- rtl/ordered_list_append_search_delete.sv -----
// Ordered list of signed 32-bit values held in a row of compare-and-shift
// cells. Request channel req carries op (append, search, delete first
// match) and value; response channel rsp carries found, status and the
// count after the operation. Exactly one response per request, in order.
// Every cell compares its entry with the key at once; the first-match flag
// ripples from the head cell toward the tail, and on a delete every cell at
// or after the match takes its right neighbor's entry in the same cycle.
// The response is registered at the edge that accepts the request. One request
// per cycle is accepted while the response register is empty or being taken;
// the compare and shift across the row of cells both complete at that edge.
// req.ready is high whenever the response register is empty or is being
// taken, so a stalled receiver holds the response and blocks new requests
// only until it is taken. Synchronous reset empties the list (count zero)
// and drops any pending response; entry contents are not cleared, since
// only entries below the count are ever compared.
// Depends on olasd_pkg, olasd_if, olasd_cell and olasd_top_ctrl.
module ordered_list_append_search_delete
  import olasd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  olasd_req_if.sink   req,
  olasd_rsp_if.source rsp
);

  cell_ctrl_t         ctrl;
  logic [VALUE_W-1:0] entries [DEPTH];
  logic [DEPTH:0]     prior;

  assign prior[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] next_entry;
    if (i == DEPTH - 1) begin : g_tail
      // The last cell leaves the held range when it shifts; its value is dead.
      assign next_entry = '0;
    end else begin : g_mid
      assign next_entry = entries[i+1];
    end

    olasd_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .index      (IDX_W'(i)),
      .next_entry (next_entry),
      .prior_in   (prior[i]),
      .prior_out  (prior[i+1]),
      .entry      (entries[i])
    );
  end

  olasd_top_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_op     (req.op),
    .req_key    (req.value),
    .match_any  (prior[DEPTH]),
    .ctrl       (ctrl),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_found  (rsp.found),
    .rsp_status (rsp.status),
    .rsp_count  (rsp.count)
  );

endmodule

// ----- sim/ordered_list_append_search_delete_tb.sv -----
// Self-checking testbench for the ordered list block: a queue-fed request
// driver, a response monitor and an in-bench model of the list contents.
// Depends on olasd_pkg, olasd_if and the ordered_list_append_search_delete RTL.
`timescale 1ns / 100ps

module ordered_list_append_search_delete_tb;
  import olasd_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int N_RANDOM   = 1325;
  localparam int POOL_N     = 12;
  localparam int HOLD_AFTER = 500;
  localparam int HOLD_LEN   = 64;

  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  localparam int RX_STEADY  = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_PATTERN = 2;

  typedef struct packed {
    logic [1:0]          op;
    logic [VALUE_W-1:0]  value;
  } list_req_t;

  typedef struct packed {
    logic                 found;
    logic [1:0]           status;
    logic [OUT_CNT_W-1:0] count;
  } list_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  olasd_req_if req_ch ();
  olasd_rsp_if rsp_ch ();

  ordered_list_append_search_delete u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  list_req_t pending_reqs [$];
  list_rsp_t expected_rsps [$];

  // Model of what the block holds.
  logic [VALUE_W-1:0] held_vals [DEPTH];
  int held_count = 0;

  int n_errors   = 0;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_found    = 0;
  int n_full     = 0;
  int n_missed   = 0;
  int peak_count = 0;
  bit hold_done  = 1'b0;

  function automatic list_rsp_t apply_list_op(list_req_t r);
    list_rsp_t res;
    int hit;
    res.found  = 1'b0;
    res.status = ST_OK;
    hit = -1;
    for (int i = held_count - 1; i >= 0; i--) begin
      if (held_vals[i] == r.value) hit = i;
    end
    case (r.op)
      OP_APPEND: begin
        if (held_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          held_vals[held_count] = r.value;
          held_count++;
        end
      end
      OP_SEARCH: begin
        res.found = (hit >= 0);
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          res.found = 1'b1;
          for (int i = hit; i < held_count - 1; i++) held_vals[i] = held_vals[i + 1];
          held_count--;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    res.count = OUT_CNT_W'(held_count);
    return res;
  endfunction

  function automatic void check_field(string fname, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      n_errors++;
    end
  endfunction

  // Request driver: sends bursts from the pending queue with random gaps.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    list_rsp_t exp_rsp;
    bit        holding;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.op    <= OP_APPEND;
      req_ch.value <= '0;
    end else begin
      holding = req_ch.valid && !req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        exp_rsp = apply_list_op(pending_reqs[0]);
        expected_rsps.push_back(exp_rsp);
        pending_reqs.pop_front();
        n_accepted++;
        if (exp_rsp.found) n_found++;
        if (exp_rsp.status == ST_FULL) n_full++;
        if (exp_rsp.status == ST_NOT_FOUND) n_missed++;
        if (held_count > peak_count) peak_count = held_count;
      end
      // A request that is waiting on ready stays on the bus unchanged.
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_ch.valid <= 1'b1;
          req_ch.op    <= pending_reqs[0].op;
          req_ch.value <= pending_reqs[0].value;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response receiver: the stall pattern is re-drawn at random among steady,
  // random and fixed-pattern modes, plus one long hold-off partway through so that the block backs up onto its input.
  int rx_cycle  = 0;
  int rx_mode   = RX_STEADY;
  int hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 256 == 0) rx_mode <= $urandom_range(RX_STEADY, RX_PATTERN);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_ch.ready <= 1'b0;
      end else if (!hold_done && n_checked >= HOLD_AFTER) begin
        hold_left <= HOLD_LEN - 1;
        hold_done <= 1'b1;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_RANDOM:  rsp_ch.ready <= ($urandom_range(0, 99) < 65);
          RX_PATTERN: rsp_ch.ready <= (rx_cycle % 7 < 4);
          default:    rsp_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // Response monitor.
  always @(posedge clk) begin
    list_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      n_checked <= n_checked + 1;
      if (expected_rsps.size() == 0) begin
        $display("%0t ns: response with none expected, actual found=%0d status=%0d count=%0d",
                 $time, rsp_ch.found, rsp_ch.status, rsp_ch.count);
        n_errors++;
      end else begin
        want = expected_rsps.pop_front();
        check_field("found", want.found, rsp_ch.found);
        check_field("status", want.status, rsp_ch.status);
        check_field("count", want.count, rsp_ch.count);
      end
    end
  end

  task automatic add_req(logic [1:0] op, logic [VALUE_W-1:0] value);
    list_req_t r;
    r.op    = op;
    r.value = value;
    pending_reqs.push_back(r);
  endtask

  initial begin : stimulus
    logic [VALUE_W-1:0] pool [POOL_N];
    logic [VALUE_W-1:0] val;
    logic [1:0]         op;
    int phase_left;
    int mode;
    int pick;

    req_ch.valid = 1'b0;
    req_ch.op    = OP_APPEND;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;

    // Directed opening: empty list, extremes, middle and head deletes,
    // duplicates, and removing the only entry.
    add_req(OP_SEARCH, 32'h0000_0000);
    add_req(OP_DELETE, 32'h0000_0000);
    add_req(OP_UNUSED, 32'hFFFF_FFFF);
    add_req(OP_APPEND, 32'h8000_0000);
    add_req(OP_APPEND, 32'h7FFF_FFFF);
    add_req(OP_APPEND, 32'hFFFF_FFFF);
    add_req(OP_APPEND, 32'h0000_0000);
    add_req(OP_SEARCH, 32'h8000_0000);
    add_req(OP_SEARCH, 32'h0000_0001);
    add_req(OP_DELETE, 32'h7FFF_FFFF);
    add_req(OP_SEARCH, 32'hFFFF_FFFF);
    add_req(OP_APPEND, 32'h7FFF_FFFF);
    add_req(OP_SEARCH, 32'h7FFF_FFFF);
    add_req(OP_APPEND, 32'h0000_0000);
    add_req(OP_DELETE, 32'h0000_0000);
    add_req(OP_SEARCH, 32'h0000_0000);
    add_req(OP_DELETE, 32'h0000_0000);
    add_req(OP_DELETE, 32'h0000_0000);
    add_req(OP_DELETE, 32'h8000_0000);
    add_req(OP_DELETE, 32'hFFFF_FFFF);
    add_req(OP_DELETE, 32'h7FFF_FFFF);
    add_req(OP_APPEND, 32'h5555_5555);
    add_req(OP_DELETE, 32'h5555_5555);
    add_req(OP_APPEND, 32'hAAAA_AAAA);
    add_req(OP_SEARCH, 32'hAAAA_AAAA);

    // Most keys come from a small pool so that searches and deletes hit.
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7FFF_FFFF;
    pool[2] = 32'hFFFF_FFFF;
    pool[3] = 32'h0000_0000;
    for (int i = 4; i < POOL_N; i++) pool[i] = $urandom;

    phase_left = 0;
    mode = MODE_FILL;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 60);
        mode = $urandom_range(MODE_FILL, MODE_MIXED);
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      if (pick == 0) begin
        op = OP_UNUSED;
      end else begin
        case (mode)
          MODE_FILL:  op = (pick < 71) ? OP_APPEND : (pick < 91) ? OP_SEARCH : OP_DELETE;
          MODE_DRAIN: op = (pick < 16) ? OP_APPEND : (pick < 41) ? OP_SEARCH : OP_DELETE;
          default:    op = (pick < 41) ? OP_APPEND : (pick < 71) ? OP_SEARCH : OP_DELETE;
        endcase
      end
      val = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, POOL_N - 1)] : $urandom;
      add_req(op, val);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d requests: %0d hits, %0d appends refused as full, %0d deletes missed.",
             n_accepted, n_found, n_full, n_missed);
    $display("Checked %0d responses; list filled to %0d of %0d; long receiver hold-off %s.",
             n_checked, peak_count, DEPTH, hold_done ? "applied" : "not reached");
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("Timed out with %0d requests pending and %0d responses outstanding.",
             pending_reqs.size(), expected_rsps.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/olasd_pkg.sv
rtl/olasd_if.sv
rtl/olasd_cell.sv
rtl/olasd_top_ctrl.sv
rtl/ordered_list_append_search_delete.sv
sim/ordered_list_append_search_delete_tb.sv
